FILE: rtl/lpm_pkg.sv
// ---------------------------------------------------------------------------
// lpm_pkg
// Shared constants, command codes and types of the latency percentile
// monitor: ring size, field widths, sorter cell modes and sequencer states.
// ---------------------------------------------------------------------------
package lpm_pkg;

   // ring size and derived widths
   localparam int RING_DEPTH  = 256;
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int SAMPLE_W    = 32;
   localparam int CTR_W       = 64;
   localparam int CMD_W       = 3;
   localparam int COUNT_OUT_W = 9;

   // percentile arithmetic: n*k and j*100 both stay below 2^(CNT_W+7)
   localparam int PCT_W   = CNT_W + 7;
   localparam int PCT_DIV = 100;
   localparam int PCT_K50 = 50;
   localparam int PCT_K95 = 95;
   localparam int PCT_K99 = 99;

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_RECORD,
      CMD_ORDER,
      CMD_TRADE,
      CMD_CANCEL,
      CMD_READ
   } lpm_cmd_type;

   // one sample slot: valid means a nonzero sample is held
   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] value;
   } lpm_entry_type;

   // sorter cell operation, broadcast to every cell
   typedef enum logic [1:0] {
      SORT_HOLD,
      SORT_CLEAR,
      SORT_INSERT,
      SORT_SHIFT
   } lpm_sort_mode_type;

   // statistics read sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DRAIN,
      ST_PICK,
      ST_FINISH
   } lpm_state_type;

endpackage

FILE: rtl/latency_percentile_monitor.sv
// ---------------------------------------------------------------------------
// latency_percentile_monitor
// Event monitor: a ring of the latest latency samples, three wrapping event
// counters, and a statistics read that reports the sample count and the
// p50, p95 and p99 latencies of the nonzero samples in the ring.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_cmd, req_latency_ns
//   rsp_      out        rsp_valid / rsp_ready  counters, count, p50/p95/p99
//
// Record, order, trade and cancel commands are taken back to back.
// A statistics read rotates the ring once into the sorter row, drains the row
// for the same length, then walks over the n sorted samples; the rotation and
// the drain are set by the length of the cell row.
// Reset empties the ring and clears the counters at once; no clearing pass.
// While a read is in progress req_ready is low; a result waits in the output
// register for rsp_ready while new events are taken.
// ---------------------------------------------------------------------------
module latency_percentile_monitor import lpm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [SAMPLE_W-1:0]    req_latency_ns,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CTR_W-1:0]       rsp_orders_total,
   output logic [CTR_W-1:0]       rsp_trades_total,
   output logic [CTR_W-1:0]       rsp_cancels_total,
   output logic [COUNT_OUT_W-1:0] rsp_sample_count,
   output logic [SAMPLE_W-1:0]    rsp_pct50_latency,
   output logic [SAMPLE_W-1:0]    rsp_pct95_latency,
   output logic [SAMPLE_W-1:0]    rsp_pct99_latency
);

   lpm_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [PCT_W-1:0]    acc_ff, acc_in;
   logic [PCT_W-1:0]    nk50_ff, nk95_ff, nk99_ff;
   logic [SAMPLE_W-1:0] p50_ff, p50_in, p95_ff, p95_in, p99_ff, p99_in;
   logic [CTR_W-1:0]    orders_ff, orders_in, trades_ff, trades_in;
   logic [CTR_W-1:0]    cancels_ff, cancels_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CTR_W-1:0]    rsp_orders_ff, rsp_trades_ff, rsp_cancels_ff;
   logic [CNT_W-1:0]    rsp_n_ff;
   logic [SAMPLE_W-1:0] rsp_p50_ff, rsp_p95_ff, rsp_p99_ff;

   logic                req_xfer;
   lpm_cmd_type         cmd_dec;
   logic                rsp_load;
   logic                ring_shift;
   lpm_entry_type       ring_head;
   lpm_sort_mode_type   sort_mode;
   lpm_entry_type       sort_head;
   logic [SAMPLE_W-1:0] pick_value;
   logic [PCT_W:0]      acc_hi;

   lpm_entry_type ring_link [0:RING_DEPTH];
   lpm_entry_type sort_link [0:RING_DEPTH];
   lpm_entry_type held_link [0:RING_DEPTH];

   assign req_xfer = req_valid && req_ready;
   assign cmd_dec  = lpm_cmd_type'(req_cmd);

   // sample ring: shift line of cells
   assign ring_link[0] = ring_head;
   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_ring
      lpm_ring_cell u_ring_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (ring_shift),
         .entry_in  (ring_link[i]),
         .entry_out (ring_link[i+1])
      );
   end

   // sorter row: values enter on the left, shift out to the left
   assign sort_link[0]          = sort_head;
   assign held_link[RING_DEPTH] = '0;
   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_sort
      lpm_sort_cell u_sort_cell (
         .clock      (clock),
         .reset      (reset),
         .mode       (sort_mode),
         .entry_in   (sort_link[i]),
         .right_held (held_link[i+1]),
         .pass_out   (sort_link[i+1]),
         .held_out   (held_link[i])
      );
   end

   // value at the sorted position currently in the first cell
   assign pick_value = held_link[0].valid ? held_link[0].value : '0;
   assign acc_hi     = (PCT_W+1)'(acc_ff) + (PCT_W+1)'(PCT_DIV);

   // read sequencer: next state and controls
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      acc_in     = acc_ff;
      p50_in     = p50_ff;
      p95_in     = p95_ff;
      p99_in     = p99_ff;
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      ring_shift = 1'b0;
      ring_head.valid = (req_latency_ns != '0);
      ring_head.value = req_latency_ns;
      sort_mode  = SORT_HOLD;
      sort_head  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (cmd_dec == CMD_RECORD) begin
                  ring_shift = 1'b1;
               end
               if (cmd_dec == CMD_READ) begin
                  sort_mode = SORT_CLEAR;
                  cnt_in    = '0;
                  n_in      = '0;
                  p50_in    = '0;
                  p95_in    = '0;
                  p99_in    = '0;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // rotate the ring once, feeding each entry to the sorter
            ring_shift = 1'b1;
            ring_head  = ring_link[RING_DEPTH];
            sort_mode  = SORT_INSERT;
            sort_head  = ring_link[RING_DEPTH];
            n_in       = n_ff + CNT_W'(ring_link[RING_DEPTH].valid);
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RING_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // let the last passed values settle
            sort_mode = SORT_INSERT;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RING_DEPTH - 1)) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // position j is picked when j*100 <= n*k < (j+1)*100
            sort_mode = SORT_SHIFT;
            if ((acc_ff <= nk50_ff) && (acc_hi > (PCT_W+1)'(nk50_ff))) begin
               p50_in = pick_value;
            end
            if ((acc_ff <= nk95_ff) && (acc_hi > (PCT_W+1)'(nk95_ff))) begin
               p95_in = pick_value;
            end
            if ((acc_ff <= nk99_ff) && (acc_hi > (PCT_W+1)'(nk99_ff))) begin
               p99_in = pick_value;
            end
            acc_in = acc_ff + PCT_W'(PCT_DIV);
            cnt_in = cnt_ff + CNT_W'(1);
            if ((CNT_W+1)'(cnt_ff) + (CNT_W+1)'(1) >= (CNT_W+1)'(n_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      acc_ff  <= acc_in;
      p50_ff  <= p50_in;
      p95_ff  <= p95_in;
      p99_ff  <= p99_in;
      nk50_ff <= PCT_W'(n_ff) * PCT_W'(PCT_K50);
      nk95_ff <= PCT_W'(n_ff) * PCT_W'(PCT_K95);
      nk99_ff <= PCT_W'(n_ff) * PCT_W'(PCT_K99);
   end

   // event counters
   always_comb begin
      orders_in  = orders_ff;
      trades_in  = trades_ff;
      cancels_in = cancels_ff;
      if (req_xfer) begin
         unique case (cmd_dec)
            CMD_ORDER:  orders_in  = orders_ff + CTR_W'(1);
            CMD_TRADE:  trades_in  = trades_ff + CTR_W'(1);
            CMD_CANCEL: cancels_in = cancels_ff + CTR_W'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orders_ff  <= '0;
         trades_ff  <= '0;
         cancels_ff <= '0;
      end else begin
         orders_ff  <= orders_in;
         trades_ff  <= trades_in;
         cancels_ff <= cancels_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_orders_ff  <= orders_ff;
         rsp_trades_ff  <= trades_ff;
         rsp_cancels_ff <= cancels_ff;
         rsp_n_ff       <= n_ff;
         rsp_p50_ff     <= p50_ff;
         rsp_p95_ff     <= p95_ff;
         rsp_p99_ff     <= p99_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_orders_total  = rsp_orders_ff;
   assign rsp_trades_total  = rsp_trades_ff;
   assign rsp_cancels_total = rsp_cancels_ff;
   assign rsp_sample_count  = COUNT_OUT_W'(rsp_n_ff);
   assign rsp_pct50_latency = rsp_p50_ff;
   assign rsp_pct95_latency = rsp_p95_ff;
   assign rsp_pct99_latency = rsp_p99_ff;

   // percentiles come out of a sorted row, so they are ordered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pct50_latency <= rsp_pct95_latency) &&
                    (rsp_pct95_latency <= rsp_pct99_latency))
      else $error("percentiles out of order");

   // an empty ring reports zero percentiles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_n_ff == '0) |->
         (rsp_pct50_latency == '0) && (rsp_pct95_latency == '0) &&
         (rsp_pct99_latency == '0))
      else $error("nonzero percentile with no samples");

   // the order counter moves only on an order transfer
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (orders_ff != $past(orders_ff)) |->
         $past(req_valid && req_ready && (req_cmd == CMD_ORDER)))
      else $error("order counter changed without an order transfer");

endmodule

FILE: rtl/lpm_ring_cell.sv
// ---------------------------------------------------------------------------
// lpm_ring_cell
// One stage of the sample ring. The ring is a shift line: a new sample
// enters the first stage and the oldest falls off the last one. During a
// statistics read the line is rotated once through its full length.
// ---------------------------------------------------------------------------
module lpm_ring_cell import lpm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  lpm_entry_type entry_in,
   output lpm_entry_type entry_out
);

   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   // take the neighbor's entry on a shift
   always_comb begin
      valid_in  = valid_ff;
      sample_in = sample_ff;
      if (shift_en) begin
         valid_in  = entry_in.valid;
         sample_in = entry_in.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.value = sample_ff;

endmodule

FILE: rtl/lpm_sort_cell.sv
// ---------------------------------------------------------------------------
// lpm_sort_cell
// One cell of the systolic insertion sorter. In insert mode the cell keeps
// the smaller of its held value and the arriving one and hands the larger
// to its right neighbor through its registered pass output. In shift mode the sorted row moves
// one place to the left, so the first cell presents the values in order.
// ---------------------------------------------------------------------------
module lpm_sort_cell import lpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lpm_sort_mode_type mode,
   input  lpm_entry_type     entry_in,
   input  lpm_entry_type     right_held,
   output lpm_entry_type     pass_out,
   output lpm_entry_type     held_out
);

   logic                held_valid_ff, held_valid_in;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic                pass_valid_ff, pass_valid_in;
   logic [SAMPLE_W-1:0] pass_ff, pass_in;

   // insert, clear or shift
   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      pass_valid_in = pass_valid_ff;
      pass_in       = pass_ff;
      case (mode)
         SORT_CLEAR: begin
            held_valid_in = 1'b0;
            pass_valid_in = 1'b0;
         end
         SORT_INSERT: begin
            pass_valid_in = 1'b0;
            if (entry_in.valid) begin
               if (!held_valid_ff || (entry_in.value < held_ff)) begin
                  held_valid_in = 1'b1;
                  held_in       = entry_in.value;
                  pass_valid_in = held_valid_ff;
                  pass_in       = held_ff;
               end else begin
                  pass_valid_in = 1'b1;
                  pass_in       = entry_in.value;
               end
            end
         end
         SORT_SHIFT: begin
            held_valid_in = right_held.valid;
            held_in       = right_held.value;
            pass_valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      pass_ff <= pass_in;
   end

   assign pass_out.valid = pass_valid_ff;
   assign pass_out.value = pass_ff;
   assign held_out.valid = held_valid_ff;
   assign held_out.value = held_ff;

endmodule

FILE: dv/latency_percentile_monitor_test.sv
// ---------------------------------------------------------------------------
// latency_percentile_monitor_test
// Self-checking bench for the latency percentile monitor. A queue of command
// transfers is filled up front: a short directed opening, then episodes of
// latency samples and event counts, each closed by a statistics read. Some
// episodes fill and wrap the whole ring. A scoreboard copy of the ring and
// the counters predicts every statistics result, which is compared field by
// field as it leaves the block. Both channels idle at random.
// ---------------------------------------------------------------------------
module latency_percentile_monitor_test;
   import lpm_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS = 650;
   localparam int READ_TARGET  = 40;
   localparam int MAX_GAP      = 16;
   localparam int SETTLE_CYC   = 3 * RING_DEPTH + 32;
   localparam int CYCLE_LIMIT  = 3000000;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   // latency value styles of an episode
   localparam int STYLE_TINY    = 0;
   localparam int STYLE_FULL    = 1;
   localparam int STYLE_EXTREME = 2;
   localparam int STYLE_MID     = 3;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [SAMPLE_W-1:0] lat;
   } event_item_type;

   typedef struct {
      logic [CTR_W-1:0]       orders;
      logic [CTR_W-1:0]       trades;
      logic [CTR_W-1:0]       cancels;
      logic [COUNT_OUT_W-1:0] count;
      logic [SAMPLE_W-1:0]    p50;
      logic [SAMPLE_W-1:0]    p95;
      logic [SAMPLE_W-1:0]    p99;
   } stats_rec_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_cmd = '0;
   logic [SAMPLE_W-1:0]    req_latency_ns = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CTR_W-1:0]       rsp_orders_total;
   logic [CTR_W-1:0]       rsp_trades_total;
   logic [CTR_W-1:0]       rsp_cancels_total;
   logic [COUNT_OUT_W-1:0] rsp_sample_count;
   logic [SAMPLE_W-1:0]    rsp_pct50_latency;
   logic [SAMPLE_W-1:0]    rsp_pct95_latency;
   logic [SAMPLE_W-1:0]    rsp_pct99_latency;

   // stimulus and scoreboard
   event_item_type      event_q[$];
   stats_rec_type       stats_due_q[$];
   logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
   int unsigned         ring_wr;
   logic [CTR_W-1:0]    order_tally;
   logic [CTR_W-1:0]    trade_tally;
   logic [CTR_W-1:0]    cancel_tally;

   int  fail_count = 0;
   int  reads_checked = 0;
   int  events_taken = 0;
   int  peak_fill = 0;
   int  items_counted = 0;
   int  reads_queued = 0;
   int  cycle_count = 0;

   // handshake flags seen at the rising edge
   logic req_accepted = 1'b0;
   logic rsp_taken = 1'b0;
   logic rsp_seen = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   bit   req_quiet = 1'b0;
   bit   rsp_quiet = 1'b0;

   latency_percentile_monitor u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_latency_ns    (req_latency_ns),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_orders_total  (rsp_orders_total),
      .rsp_trades_total  (rsp_trades_total),
      .rsp_cancels_total (rsp_cancels_total),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_pct50_latency (rsp_pct50_latency),
      .rsp_pct95_latency (rsp_pct95_latency),
      .rsp_pct99_latency (rsp_pct99_latency)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // percentile rank over an ascending list, clamped to the last entry
   function automatic logic [SAMPLE_W-1:0] rank_value(input logic [SAMPLE_W-1:0] vals[$],
                                                      input int k);
      int idx;
      if (vals.size() == 0) return '0;
      idx = (vals.size() * k) / PCT_DIV;
      if (idx >= vals.size()) idx = vals.size() - 1;
      return vals[idx];
   endfunction

   // statistics over the nonzero samples of the ring copy
   function automatic stats_rec_type ring_stats();
      stats_rec_type       s;
      logic [SAMPLE_W-1:0] held_q[$];
      foreach (ring_copy[i]) begin
         if (ring_copy[i] != '0) held_q.insert(held_q.size(), ring_copy[i]);
      end
      held_q.sort();
      s.orders  = order_tally;
      s.trades  = trade_tally;
      s.cancels = cancel_tally;
      s.count   = COUNT_OUT_W'(held_q.size());
      s.p50     = rank_value(held_q, PCT_K50);
      s.p95     = rank_value(held_q, PCT_K95);
      s.p99     = rank_value(held_q, PCT_K99);
      if (held_q.size() > peak_fill) peak_fill = held_q.size();
      return s;
   endfunction

   // update the scoreboard copy for one accepted command
   task automatic apply_event(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] lat);
      events_taken++;
      case (cmd)
         CMD_RECORD: begin
            ring_copy[ring_wr] = lat;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
         end
         CMD_ORDER:  order_tally  = order_tally + 1'b1;
         CMD_TRADE:  trade_tally  = trade_tally + 1'b1;
         CMD_CANCEL: cancel_tally = cancel_tally + 1'b1;
         CMD_READ:   stats_due_q.insert(stats_due_q.size(), ring_stats());
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [CTR_W-1:0] want,
                                input logic [CTR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // compare one result transfer with the oldest prediction
   task automatic check_stats();
      stats_rec_type want;
      if (stats_due_q.size() == 0) begin
         $error("statistics result with no read outstanding");
         fail_count++;
      end else begin
         want = stats_due_q.pop_front();
         reads_checked++;
         compare_field("orders_total", want.orders, rsp_orders_total);
         compare_field("trades_total", want.trades, rsp_trades_total);
         compare_field("cancels_total", want.cancels, rsp_cancels_total);
         compare_field("sample_count", CTR_W'(want.count), CTR_W'(rsp_sample_count));
         compare_field("pct50_latency", CTR_W'(want.p50), CTR_W'(rsp_pct50_latency));
         compare_field("pct95_latency", CTR_W'(want.p95), CTR_W'(rsp_pct95_latency));
         compare_field("pct99_latency", CTR_W'(want.p99), CTR_W'(rsp_pct99_latency));
      end
   endtask

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && req_ready;
      rsp_taken    <= !reset && rsp_valid && rsp_ready;
      rsp_seen     <= !reset && rsp_valid;
      if (reset) begin
         foreach (ring_copy[i]) ring_copy[i] = '0;
         ring_wr      = 0;
         order_tally  = '0;
         trade_tally  = '0;
         cancel_tally = '0;
      end else begin
         if (rsp_valid && rsp_ready) check_stats();
         if (req_valid && req_ready) apply_event(req_cmd, req_latency_ns);
      end
   end

   // request driver: one transfer at a time from the queue, random gaps
   always @(negedge clock) begin : req_driver
      logic           next_valid;
      event_item_type item;
      next_valid = req_valid;
      if (!reset) begin
         if (req_valid && req_accepted) begin
            next_valid = 1'b0;
            if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
            req_gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (!next_valid && event_q.size() != 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               item = event_q.pop_front();
               req_cmd        <= item.cmd;
               req_latency_ns <= item.lat;
               next_valid     = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // result side: hold rsp_ready low for a random stall once a result shows up
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            if ($urandom_range(0, 5) == 0) rsp_quiet = !rsp_quiet;
            rsp_hold = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end else if (rsp_seen && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("latency_percentile_monitor test failed");
         $finish;
      end
   end

   task automatic add_event(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] lat);
      event_item_type item;
      item.cmd = cmd;
      item.lat = lat;
      event_q.insert(event_q.size(), item);
      if (cmd < CMD_UNUSED_FIRST) items_counted++;
      if (cmd == CMD_READ) reads_queued++;
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_latency(input int style, input int zero_pct);
      int bit_pos;
      bit_pos = $urandom_range(0, SAMPLE_W - 1);
      if ($urandom_range(0, 99) < zero_pct) return '0;
      case (style)
         STYLE_TINY: return $urandom_range(1, 16);
         STYLE_FULL: return $urandom();
         STYLE_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return 32'd1;
               1:       return 32'hFFFF_FFFF;
               2:       return 32'd1 << bit_pos;
               default: return ~(32'd1 << bit_pos);
            endcase
         end
         default: return $urandom_range(1, 100000);
      endcase
   endfunction

   // one episode of events closed by a statistics read; a fill episode
   // writes a full ring or more of nonzero samples
   task automatic add_episode(input bit fill);
      int len;
      int zero_pct;
      int style;
      int pick;
      style    = $urandom_range(STYLE_TINY, STYLE_MID);
      zero_pct = (!fill && $urandom_range(0, 2) == 0) ? 20 : 0;
      len      = fill ? RING_DEPTH + $urandom_range(0, 40) : $urandom_range(2, 30);
      for (int i = 0; i < len; i++) begin
         pick = fill ? 0 : $urandom_range(0, 99);
         if (pick < 60)      add_event(CMD_RECORD, draw_latency(style, zero_pct));
         else if (pick < 70) add_event(CMD_ORDER, $urandom());
         else if (pick < 80) add_event(CMD_TRADE, $urandom());
         else if (pick < 90) add_event(CMD_CANCEL, $urandom());
         else if (pick < 96) add_event(CMD_READ, $urandom());
         else add_event(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                        $urandom());
      end
      add_event(CMD_READ, $urandom());
   endtask

   // stimulus and end of run
   initial begin
      int episode;

      // directed opening: empty read, counters, extremes, zero sample,
      // duplicates and the unused commands
      add_event(CMD_READ, '0);
      add_event(CMD_ORDER, '0);
      add_event(CMD_TRADE, '1);
      add_event(CMD_CANCEL, '0);
      add_event(CMD_RECORD, 32'hFFFF_FFFF);
      add_event(CMD_READ, '1);
      add_event(CMD_RECORD, '0);
      add_event(CMD_RECORD, 32'd1);
      add_event(CMD_RECORD, 32'hFFFF_FFFF);
      add_event(CMD_READ, '0);
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
         add_event(CMD_W'(c), $urandom());
      end
      add_event(CMD_RECORD, 32'h8000_0000);
      add_event(CMD_RECORD, 32'h7FFF_FFFF);
      add_event(CMD_RECORD, 32'h5555_5555);
      add_event(CMD_RECORD, 32'hAAAA_AAAA);
      add_event(CMD_ORDER, '0);
      add_event(CMD_ORDER, '1);
      add_event(CMD_READ, '0);

      // random episodes, at least one of them a full ring
      episode = 0;
      while (items_counted < RANDOM_ITEMS || reads_queued < READ_TARGET) begin
         add_episode(episode == 2 || $urandom_range(0, 11) == 0);
         episode++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain, then watch for stray results
      while (event_q.size() != 0 || req_valid || stats_due_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);

      $display("ran %0d command transfers and checked %0d statistics reads",
               events_taken, reads_checked);
      $display("ring held up to %0d nonzero samples at a read", peak_fill);
      if (fail_count == 0) begin
         $display("latency_percentile_monitor test passed");
      end else begin
         $display("latency_percentile_monitor test failed");
      end
      $finish;
   end

endmodule
